@@ hdl/mlfq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types, sizes, codes and helpers for the multi-level feedback queue
// scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int MAX_PROCS  = 16;
  localparam int MAX_LEVELS = 8;

  localparam int PID_W    = 8;
  localparam int PTR_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int LVL_W    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int NLEV_W   = LVL_W + 1;
  localparam int FILL_W   = $clog2(MAX_PROCS + 1);
  localparam int ADDR_W   = LVL_W + PTR_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  localparam int LC_W     = 4;
  localparam int PERIOD_W = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int OC_W     = 2;
  localparam int EV_W     = 3;
  localparam int OLVL_W   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_PERIOD = 1'd1;

  localparam logic KIND_ADMIT = 1'b0;
  localparam logic KIND_SLICE = 1'b1;

  localparam logic [OC_W-1:0] OC_YIELD = 2'd0;
  localparam logic [OC_W-1:0] OC_FULL  = 2'd1;

  localparam logic [LC_W-1:0]     LC_RESET     = 4'd3;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;

  typedef enum logic [EV_W-1:0] {
    EV_YIELD  = 3'd0,
    EV_FULL   = 3'd1,
    EV_EXIT   = 3'd2,
    EV_BOOST  = 3'd3,
    EV_IDLE   = 3'd4,
    EV_ADMIT  = 3'd5,
    EV_REJECT = 3'd6
  } ev_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADMIT,
    ST_SLICE,
    ST_SLICE_WB,
    ST_BOOST_RD,
    ST_BOOST_WB
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PID_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic              valid;
    ev_t               ev;
    logic [PID_W-1:0]  pid;
    logic [OLVL_W-1:0] level;
    logic              last;
  } emit_t;

  typedef struct packed {
    logic [NLEV_W-1:0]   nlev;
    logic [PERIOD_W-1:0] period;
  } sched_cfg_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    logic [PTR_W:0] t;
    t = {1'b0, ptr} + 1'b1;
    return (t >= (PTR_W+1)'(MAX_PROCS)) ? '0 : t[PTR_W-1:0];
  endfunction

endpackage

@@ hdl/mlfq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_ram
// Queue storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mlfq_ram (
  input  logic                           clk,
  input  mlfq_pkg::ram_req_t             req,
  output logic [mlfq_pkg::PID_W-1:0]     rdata
);

  logic [mlfq_pkg::PID_W-1:0] mem [mlfq_pkg::RAM_DEPTH];
  logic [mlfq_pkg::PID_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/mlfq_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_seq
// Scheduler sequencer: per-level ring pointers and fills, slice counter,
// queue RAM read/modify/write and result generation.
// ----------------------------------------------------------------------------
module mlfq_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mlfq_pkg::sched_cfg_t          cfg,
  input  logic                          in_valid,
  input  logic                          in_kind,
  input  logic [mlfq_pkg::PID_W-1:0]    in_pid,
  input  logic [mlfq_pkg::OC_W-1:0]     in_oc,
  output logic                          in_ready,
  input  logic                          out_free,
  output mlfq_pkg::emit_t               emit,
  output mlfq_pkg::ram_req_t            ram_req,
  input  logic [mlfq_pkg::PID_W-1:0]    ram_rdata
);

  localparam int ML = mlfq_pkg::MAX_LEVELS;

  mlfq_pkg::state_t state_r, state_nxt;

  logic [mlfq_pkg::PTR_W-1:0]    head_r [ML];
  logic [mlfq_pkg::PTR_W-1:0]    head_nxt [ML];
  logic [mlfq_pkg::PTR_W-1:0]    tail_r [ML];
  logic [mlfq_pkg::PTR_W-1:0]    tail_nxt [ML];
  logic [mlfq_pkg::FILL_W-1:0]   fill_r [ML];
  logic [mlfq_pkg::FILL_W-1:0]   fill_nxt [ML];
  logic [mlfq_pkg::FILL_W-1:0]   total_r, total_nxt;
  logic [mlfq_pkg::PERIOD_W-1:0] cnt_r, cnt_nxt;

  logic [mlfq_pkg::PID_W-1:0]    pid_r, pid_nxt;
  logic [mlfq_pkg::OC_W-1:0]     oc_r, oc_nxt;
  logic [mlfq_pkg::LVL_W-1:0]    cur_lvl_r, cur_lvl_nxt;

  // decode
  logic                          top_found, low_found;
  logic [mlfq_pkg::LVL_W-1:0]    top_lvl, low_lvl;
  logic                          push_en;
  logic [mlfq_pkg::LVL_W-1:0]    push_lvl;
  logic [mlfq_pkg::PERIOD_W-1:0] cnt_inc;
  logic                          boost_go, lower_after, full;

  always_comb begin
    top_found = 1'b0;
    top_lvl   = '0;
    for (int i = ML - 1; i >= 0; i--) begin
      if (fill_r[i] != '0) begin
        top_found = 1'b1;
        top_lvl   = mlfq_pkg::LVL_W'(i);
      end
    end
    low_found = 1'b0;
    low_lvl   = '0;
    for (int i = ML - 1; i >= 1; i--) begin
      if (fill_r[i] != '0) begin
        low_found = 1'b1;
        low_lvl   = mlfq_pkg::LVL_W'(i);
      end
    end

    // requeue target for the process that just ran
    push_en  = (oc_r == mlfq_pkg::OC_YIELD) || (oc_r == mlfq_pkg::OC_FULL);
    push_lvl = cur_lvl_r;
    if (oc_r == mlfq_pkg::OC_FULL &&
        ({1'b0, cur_lvl_r} + 1'b1) < cfg.nlev) begin
      push_lvl = cur_lvl_r + 1'b1;
    end

    cnt_inc     = cnt_r + 1'b1;
    boost_go    = cnt_inc >= cfg.period;
    lower_after = low_found || (push_en && push_lvl != '0);
    full        = total_r >= mlfq_pkg::FILL_W'(mlfq_pkg::MAX_PROCS);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mlfq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_kind == mlfq_pkg::KIND_SLICE) ? mlfq_pkg::ST_SLICE
                                                        : mlfq_pkg::ST_ADMIT;
        end
      end
      mlfq_pkg::ST_ADMIT: begin
        if (out_free) state_nxt = mlfq_pkg::ST_IDLE;
      end
      mlfq_pkg::ST_SLICE: begin
        if (top_found) state_nxt = mlfq_pkg::ST_SLICE_WB;
        else if (out_free) state_nxt = mlfq_pkg::ST_IDLE;
      end
      mlfq_pkg::ST_SLICE_WB: begin
        if (out_free) begin
          state_nxt = (boost_go && lower_after) ? mlfq_pkg::ST_BOOST_RD
                                                : mlfq_pkg::ST_IDLE;
        end
      end
      mlfq_pkg::ST_BOOST_RD: begin
        state_nxt = mlfq_pkg::ST_BOOST_WB;
      end
      mlfq_pkg::ST_BOOST_WB: begin
        if (out_free) begin
          state_nxt = low_found ? mlfq_pkg::ST_BOOST_RD : mlfq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mlfq_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    fill_nxt    = fill_r;
    total_nxt   = total_r;
    cnt_nxt     = cnt_r;
    pid_nxt     = pid_r;
    oc_nxt      = oc_r;
    cur_lvl_nxt = cur_lvl_r;
    in_ready    = 1'b0;
    ram_req     = '0;
    emit        = '0;
    emit.ev     = mlfq_pkg::EV_IDLE;

    case (state_r)
      mlfq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pid_nxt = in_pid;
          oc_nxt  = in_oc;
        end
      end
      mlfq_pkg::ST_ADMIT: begin
        if (out_free) begin
          emit.valid = 1'b1;
          emit.pid   = pid_r;
          emit.last  = 1'b1;
          if (full) begin
            emit.ev = mlfq_pkg::EV_REJECT;
          end else begin
            emit.ev       = mlfq_pkg::EV_ADMIT;
            ram_req.we    = 1'b1;
            ram_req.waddr = {mlfq_pkg::LVL_W'(0), tail_r[0]};
            ram_req.wdata = pid_r;
            tail_nxt[0]   = mlfq_pkg::ptr_inc(tail_r[0]);
            fill_nxt[0]   = fill_r[0] + 1'b1;
            total_nxt     = total_r + 1'b1;
          end
        end
      end
      mlfq_pkg::ST_SLICE: begin
        if (top_found) begin
          ram_req.re        = 1'b1;
          ram_req.raddr     = {top_lvl, head_r[top_lvl]};
          head_nxt[top_lvl] = mlfq_pkg::ptr_inc(head_r[top_lvl]);
          fill_nxt[top_lvl] = fill_r[top_lvl] - 1'b1;
          cur_lvl_nxt       = top_lvl;
        end else if (out_free) begin
          emit.valid = 1'b1;
          emit.ev    = mlfq_pkg::EV_IDLE;
          emit.last  = 1'b1;
        end
      end
      mlfq_pkg::ST_SLICE_WB: begin
        if (out_free) begin
          emit.valid = 1'b1;
          emit.pid   = ram_rdata;
          emit.last  = !(boost_go && lower_after);
          cnt_nxt    = boost_go ? '0 : cnt_inc;
          if (push_en) begin
            emit.ev            = (oc_r == mlfq_pkg::OC_YIELD) ? mlfq_pkg::EV_YIELD
                                                              : mlfq_pkg::EV_FULL;
            emit.level         = mlfq_pkg::OLVL_W'(push_lvl);
            ram_req.we         = 1'b1;
            ram_req.waddr      = {push_lvl, tail_r[push_lvl]};
            ram_req.wdata      = ram_rdata;
            tail_nxt[push_lvl] = mlfq_pkg::ptr_inc(tail_r[push_lvl]);
            fill_nxt[push_lvl] = fill_r[push_lvl] + 1'b1;
          end else begin
            // finished, or the unused code that acts as finished
            emit.ev   = mlfq_pkg::EV_EXIT;
            total_nxt = total_r - 1'b1;
          end
        end
      end
      mlfq_pkg::ST_BOOST_RD: begin
        ram_req.re        = 1'b1;
        ram_req.raddr     = {low_lvl, head_r[low_lvl]};
        head_nxt[low_lvl] = mlfq_pkg::ptr_inc(head_r[low_lvl]);
        fill_nxt[low_lvl] = fill_r[low_lvl] - 1'b1;
      end
      mlfq_pkg::ST_BOOST_WB: begin
        if (out_free) begin
          emit.valid    = 1'b1;
          emit.ev       = mlfq_pkg::EV_BOOST;
          emit.pid      = ram_rdata;
          emit.last     = !low_found;
          ram_req.we    = 1'b1;
          ram_req.waddr = {mlfq_pkg::LVL_W'(0), tail_r[0]};
          ram_req.wdata = ram_rdata;
          tail_nxt[0]   = mlfq_pkg::ptr_inc(tail_r[0]);
          fill_nxt[0]   = fill_r[0] + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlfq_pkg::ST_IDLE;
      total_r <= '0;
      cnt_r   <= '0;
      for (int i = 0; i < ML; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      cnt_r   <= cnt_nxt;
      for (int i = 0; i < ML; i++) begin
        head_r[i] <= head_nxt[i];
        tail_r[i] <= tail_nxt[i];
        fill_r[i] <= fill_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    pid_r     <= pid_nxt;
    oc_r      <= oc_nxt;
    cur_lvl_r <= cur_lvl_nxt;
  end

endmodule

@@ hdl/mlfq_scheduler_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_scheduler_unit
// Multi-level feedback queue scheduler with a stream request input, a stream
// result output and a plain configuration write port.
// ----------------------------------------------------------------------------
// Path, request to result: admit through ST_ADMIT, idle through ST_SLICE, slice
// through ST_SLICE and ST_SLICE_WB. A boost adds ST_BOOST_RD and ST_BOOST_WB per
// moved process, one result each. One request at a time; in_tready is back in
// the cycle the last result sits in the output register. A result that waits on
// out_tready stalls the sequencer.
// Reset (sync, rst_n low): queues empty, slice count 0, level_count 3,
// boost_period 100. The queue RAM is not cleared.
// ----------------------------------------------------------------------------
module mlfq_scheduler_unit (
  input  logic        clk,
  input  logic        rst_n,

  // request input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] process_id, [9:8] outcome, rest zero
  input  logic        in_tuser,   // [0] kind (0 admit, 1 slice)

  // result output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] process_id_res, [10:8] level, rest zero
  output logic [2:0]  out_tuser,  // [2:0] event_res
  output logic        out_tlast,

  // configuration
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  // Config registers; clamped copies go to the sequencer.
  logic [mlfq_pkg::LC_W-1:0]     level_count_r;
  logic [mlfq_pkg::PERIOD_W-1:0] boost_period_r;
  mlfq_pkg::sched_cfg_t          cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_count_r  <= mlfq_pkg::LC_RESET;
      boost_period_r <= mlfq_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        mlfq_pkg::CFG_LEVEL_COUNT:  level_count_r  <= cfg_wdata[mlfq_pkg::LC_W-1:0];
        mlfq_pkg::CFG_BOOST_PERIOD: boost_period_r <= cfg_wdata[mlfq_pkg::PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Level count 0 acts as 1, above MAX_LEVELS acts as MAX_LEVELS;
  // period 0 acts as 1.
  always_comb begin
    if (level_count_r == '0) begin
      cfg.nlev = mlfq_pkg::NLEV_W'(1);
    end else if ({1'b0, level_count_r} > (mlfq_pkg::LC_W+1)'(mlfq_pkg::MAX_LEVELS)) begin
      cfg.nlev = mlfq_pkg::NLEV_W'(mlfq_pkg::MAX_LEVELS);
    end else begin
      cfg.nlev = mlfq_pkg::NLEV_W'(level_count_r);
    end
    cfg.period = (boost_period_r == '0) ? mlfq_pkg::PERIOD_W'(1) : boost_period_r;
  end

  // Output register: the sequencer loads it only when it is empty or
  // being drained this cycle.
  logic                       out_valid_r;
  logic [mlfq_pkg::PID_W-1:0] out_pid_r;
  logic [mlfq_pkg::OLVL_W-1:0] out_lvl_r;
  mlfq_pkg::ev_t              out_ev_r;
  logic                       out_last_r;
  logic                       out_free;
  mlfq_pkg::emit_t            emit;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_pid_r  <= emit.pid;
      out_lvl_r  <= emit.level;
      out_ev_r   <= emit.ev;
      out_last_r <= emit.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_lvl_r, out_pid_r};
  assign out_tuser  = out_ev_r;
  assign out_tlast  = out_last_r;

  // Sequencer and queue RAM
  mlfq_pkg::ram_req_t         ram_req;
  logic [mlfq_pkg::PID_W-1:0] ram_rdata;

  mlfq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_kind   (in_tuser),
    .in_pid    (in_tdata[7:0]),
    .in_oc     (in_tdata[9:8]),
    .in_ready  (in_tready),
    .out_free  (out_free),
    .emit      (emit),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  mlfq_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // Assertions
  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> out_free)
    else $error("result loaded into a full output register");

  // one request at a time
  a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in work");

  // the last result of a request frees the input
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.valid && emit.last) |=> in_tready)
    else $error("input not ready after last result");

  // no read and write of the queue RAM in the same cycle
  a_ram_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req.we && ram_req.re))
    else $error("queue RAM read and write collide");

endmodule
